### design/whp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// whp_pkg
// Types and constants shared by the WAV header parser.
// ----------------------------------------------------------------------------
package whp_pkg;

	localparam logic [31:0] TAG_RIFF     = 32'h5249_4646;
	localparam logic [31:0] TAG_DATA     = 32'h6461_7461;
	localparam int          OFF_CH_LO    = 'h16;
	localparam int          OFF_RATE_LO  = 'h18;
	localparam int          OFF_ALIGN_LO = 'h20;
	localparam int          OFF_BPS_LO   = 'h22;
	localparam int          OFF_SEARCH   = 'h24;
	localparam int          OFF_LENGTH   = 'h28;
	localparam int          HEADER_BYTES = 'h2C;
	localparam int          RATE_MIN     = 2000;
	localparam int          RATE_MAX     = 100000;
	localparam int          OFFSET_MASK  = 'hFF;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_NOT_RIFF = 3'd1,
		ERR_NO_TAG   = 3'd2,
		ERR_TOO_LONG = 3'd3,
		ERR_CHANNELS = 3'd4,
		ERR_RATE     = 3'd5,
		ERR_ZERO     = 3'd6
	} err_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} in_t;

	typedef struct packed {
		logic        ok;
		err_t        error_code;
		logic [15:0] channels;
		logic [15:0] rate_hz;
		logic [15:0] block_align;
		logic [15:0] bits_per_sample;
		logic [31:0] data_length;
		logic [31:0] sample_count;
		logic [7:0]  tag_offset;
	} out_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

### design/whp_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// whp_in_if
// Byte channel into the parser: valid, ready and one byte word.
// ----------------------------------------------------------------------------
interface whp_in_if import whp_pkg::*; ();
	logic valid;
	logic ready;
	in_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/whp_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// whp_out_if
// Verdict channel out of the parser: valid, ready and one result word.
// ----------------------------------------------------------------------------
interface whp_out_if import whp_pkg::*; ();
	logic valid;
	logic ready;
	out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/whp_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// whp_divider
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit
// per cycle. The quotient holds with done set until the next start.
// ----------------------------------------------------------------------------
module whp_divider import whp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] div_q;

	logic [16:0] trial;
	logic        ge;
	logic [16:0] diff;

	always_comb begin
		trial = {rem_q, quo_q[31]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= req.dividend;
			rem_q  <= '0;
			div_q  <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[30:0], ge};
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

### design/wav_header_parser_unit.sv
`default_nettype none
// Timing: a verdict is registered and shown in the cycle after the deciding
// byte; a sample count, when needed, follows once the divider is done.
// Throughput: one byte per cycle; the divider stalls the byte input once per
// file that reaches the division, until its quotient is loaded. Ready also
// waits on a held result.
// Reset: asynchronous, active low; clears control state and total_size, and
// the parser stays idle until a byte marked file_start.
// ----------------------------------------------------------------------------
// wav_header_parser_unit
// Byte-serial RIFF/WAV header parser with an iterative sample-count divider.
// ----------------------------------------------------------------------------
module wav_header_parser_unit import whp_pkg::*; #(
	parameter int SEARCH_SPAN = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	whp_in_if.sink           in_ch,
	whp_out_if.source        out_ch
);

	localparam int PW = $clog2(HEADER_BYTES + SEARCH_SPAN + 1);
	localparam logic [PW-1:0] P_RIFF_END   = PW'(3);
	localparam logic [PW-1:0] P_CH_LO      = PW'(OFF_CH_LO);
	localparam logic [PW-1:0] P_CH_HI      = PW'(OFF_CH_LO + 1);
	localparam logic [PW-1:0] P_RATE_LO    = PW'(OFF_RATE_LO);
	localparam logic [PW-1:0] P_RATE_HI    = PW'(OFF_RATE_LO + 1);
	localparam logic [PW-1:0] P_ALIGN_LO   = PW'(OFF_ALIGN_LO);
	localparam logic [PW-1:0] P_ALIGN_HI   = PW'(OFF_ALIGN_LO + 1);
	localparam logic [PW-1:0] P_BPS_LO     = PW'(OFF_BPS_LO);
	localparam logic [PW-1:0] P_BPS_HI     = PW'(OFF_BPS_LO + 1);
	localparam logic [PW-1:0] P_SEARCH_END = PW'(OFF_LENGTH - 1);
	localparam logic [PW-1:0] P_LAST       = PW'(OFF_LENGTH - 1 + SEARCH_SPAN - 1);

	typedef enum logic {S_RUN, S_DIV} state_t;

	state_t      state_q;
	logic        done_q;
	logic [PW-1:0] pos_q;
	logic [31:0] win_q;
	logic [15:0] ch_q, rate_q, align_q, bps_q;
	logic [31:0] len_q;
	logic        found_q;
	logic [1:0]  k_q;
	logic [7:0]  off_q;
	logic [31:0] total_q;
	logic        out_valid_q;
	out_t        out_q;

	div_req_t    div_req;
	div_rsp_t    div_rsp;

	logic        in_fire, act, start;
	logic [7:0]  b;
	logic [PW-1:0] p, idx;
	logic [31:0] win_n;
	logic [15:0] ch_n, rate_n, align_n, bps_n;
	logic [31:0] len_n;
	logic        found_n;
	logic [1:0]  k_n;
	logic [7:0]  off_n;
	logic        done_n;
	logic        res_load;
	out_t        res;
	logic        too_long, ch_bad, rate_bad;
	logic [15:0] divisor;
	logic        go_div;
	logic        div_out;

	assign in_ch.ready = (state_q == S_RUN) && (!out_valid_q || out_ch.ready);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign start       = in_ch.data.file_start;
	assign b           = in_ch.data.data_byte;
	assign act         = in_fire && (start || !done_q);

	always_comb begin
		p       = start ? '0 : pos_q;
		idx     = p - P_SEARCH_END;
		win_n   = {(start ? 24'd0 : win_q[23:0]), b};
		ch_n    = start ? 16'd0 : ch_q;
		rate_n  = start ? 16'd0 : rate_q;
		align_n = start ? 16'd0 : align_q;
		bps_n   = start ? 16'd0 : bps_q;
		len_n   = start ? 32'd0 : len_q;
		found_n = start ? 1'b0 : found_q;
		k_n     = start ? 2'd0 : k_q;
		off_n   = start ? 8'd0 : off_q;
		done_n  = 1'b0;
		res_load = 1'b0;
		go_div   = 1'b0;
		res      = '0;
		too_long = 1'b0;
		ch_bad   = 1'b0;
		rate_bad = 1'b0;
		divisor  = '0;

		if (p == P_RIFF_END && win_n != TAG_RIFF) begin
			ch_n     = '0;
			rate_n   = '0;
			align_n  = '0;
			bps_n    = '0;
			done_n   = 1'b1;
			res_load = 1'b1;
			res.error_code = ERR_NOT_RIFF;
		end else begin
			case (p)
				P_CH_LO:    ch_n[7:0]     = b;
				P_CH_HI:    ch_n[15:8]    = b;
				P_RATE_LO:  rate_n[7:0]   = b;
				P_RATE_HI:  rate_n[15:8]  = b;
				P_ALIGN_LO: align_n[7:0]  = b;
				P_ALIGN_HI: align_n[15:8] = b;
				P_BPS_LO:   bps_n[7:0]    = b;
				P_BPS_HI:   bps_n[15:8]   = b;
				default: ;
			endcase

			res.channels        = ch_n;
			res.rate_hz         = rate_n;
			res.block_align     = align_n;
			res.bits_per_sample = bps_n;

			if (!found_n) begin
				if (p >= P_SEARCH_END) begin
					if (win_n == TAG_DATA) begin
						found_n = 1'b1;
						off_n   = 8'(idx) & 8'(OFFSET_MASK);
					end else if (p == P_LAST) begin
						done_n   = 1'b1;
						res_load = 1'b1;
						res.error_code = ERR_NO_TAG;
					end
				end
			end else begin
				case (k_n)
					2'd0:    len_n[7:0]   = b;
					2'd1:    len_n[15:8]  = b;
					2'd2:    len_n[23:16] = b;
					default: len_n[31:24] = b;
				endcase
				k_n = k_n + 2'd1;
				if (k_q == 2'd3 && !start) begin
					done_n   = 1'b1;
					too_long = ({1'b0, len_n} + 33'(HEADER_BYTES)) > {1'b0, total_q};
					ch_bad   = (ch_n != 16'd1) && (ch_n != 16'd2);
					rate_bad = ({1'b0, rate_n} > 17'(RATE_MAX)) ||
						(rate_n < 16'(RATE_MIN));
					divisor  = (ch_n == 16'd2) ? {2'd0, bps_n[15:2]} : {3'd0, bps_n[15:3]};
					res.data_length = len_n;
					res.tag_offset  = off_n;
					if (too_long) begin
						res_load = 1'b1;
						res.error_code = ERR_TOO_LONG;
					end else if (ch_bad) begin
						res_load = 1'b1;
						res.error_code = ERR_CHANNELS;
					end else if (rate_bad) begin
						res_load = 1'b1;
						res.error_code = ERR_RATE;
					end else if (divisor == 16'd0) begin
						res_load = 1'b1;
						res.error_code = ERR_ZERO;
					end else begin
						go_div = 1'b1;
					end
				end
			end
		end
		res.ok = (res.error_code == ERR_NONE);
	end

	assign div_req.start    = act && go_div;
	assign div_req.dividend = len_n;
	assign div_req.divisor  = divisor;

	assign div_out = (state_q == S_DIV) && div_rsp.done && (!out_valid_q || out_ch.ready);

	whp_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			done_q      <= 1'b1;
			pos_q       <= '0;
			win_q       <= '0;
			ch_q        <= '0;
			rate_q      <= '0;
			align_q     <= '0;
			bps_q       <= '0;
			len_q       <= '0;
			found_q     <= 1'b0;
			k_q         <= '0;
			off_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we)
				total_q <= cfg_wdata;

			if (act) begin
				pos_q   <= p + PW'(1);
				win_q   <= win_n;
				ch_q    <= ch_n;
				rate_q  <= rate_n;
				align_q <= align_n;
				bps_q   <= bps_n;
				len_q   <= len_n;
				found_q <= found_n;
				k_q     <= k_n;
				off_q   <= off_n;
				done_q  <= done_n;
				if (go_div)
					state_q <= S_DIV;
			end

			if (act && res_load) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (div_out) begin
				state_q                <= S_RUN;
				out_valid_q            <= 1'b1;
				out_q.channels         <= ch_q;
				out_q.rate_hz          <= rate_q;
				out_q.block_align      <= align_q;
				out_q.bits_per_sample  <= bps_q;
				out_q.data_length      <= len_q;
				out_q.tag_offset       <= off_q;
				out_q.sample_count     <= div_rsp.quotient;
				out_q.error_code       <= (div_rsp.quotient == 32'd0) ? ERR_ZERO : ERR_NONE;
				out_q.ok               <= (div_rsp.quotient != 32'd0);
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

endmodule
`default_nettype wire

### design/whp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// whp_checker
// Port-level checks on the parser verdict channel, bound to the top level.
// ----------------------------------------------------------------------------
module whp_checker import whp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire out_t out_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("verdict word dropped or changed while stalled");

	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.ok == (out_data.error_code == ERR_NONE))
		else $error("ok flag disagrees with error code");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_code != ERR_NONE && out_data.error_code != ERR_ZERO
		|-> out_data.sample_count == 32'd0)
		else $error("sample count set on a failed header");

	a_riff: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_code == ERR_NOT_RIFF
		|-> out_data.channels == 16'd0 && out_data.bits_per_sample == 16'd0 &&
			out_data.data_length == 32'd0 && out_data.tag_offset == 8'd0)
		else $error("fields not cleared on bad RIFF tag");

endmodule

bind wav_header_parser_unit whp_checker u_whp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
`default_nettype wire
